// ===== design/pid_controller_variable_dt_macros.svh =====
// Assertion helpers for the RTL (used by pidvdt_ctrl). Each macro expects clk and arst_n in scope.
`ifndef PID_CONTROLLER_VARIABLE_DT_MACROS_SVH
`define PID_CONTROLLER_VARIABLE_DT_MACROS_SVH

// Same-cycle implication.
`define PIDVDT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define PIDVDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/pidvdt_pkg.sv =====
`default_nettype none

package pidvdt_pkg;

	// divider geometry
	localparam int unsigned DIV_NUM_W = 64;
	localparam int unsigned DIV_REM_W = 25;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [DIV_REM_W-1:0] US_PER_S  = 25'd1000000;
	localparam logic [DIV_REM_W-1:0] DT_CAP_US = 25'h1000000;

	// radix-4 steps: derivative quotient 52 bits
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS_D = 5'd26;

	// integral scaling: x*256/1e6 == (x*4)/15625, done in base 2^16 digits;
	// ceil(2^44/15625) gives the exact digit for any 30-bit partial dividend
	localparam logic [13:0] CDIV_DEN   = 14'd15625;
	localparam logic [30:0] CDIV_RECIP = 31'd1125899907;

	// register map
	localparam logic [1:0] REG_KP = 2'd0;
	localparam logic [1:0] REG_KI = 2'd1;
	localparam logic [1:0] REG_KD = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_KI,
		S_MUL_KIDT,
		S_DIV_I,
		S_WAIT_I,
		S_INT_UPD,
		S_MUL_KD,
		S_MUL_KD6,
		S_DIV_D,
		S_WAIT_D,
		S_SUM_P,
		S_SUM_D,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_P,
		OP_MUL_KI,
		OP_MUL_KIDT,
		OP_DIV_I,
		OP_INT_UPD,
		OP_MUL_KD,
		OP_MUL_KD6,
		OP_DIV_D,
		OP_SUM_P,
		OP_SUM_D,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/pidvdt_div.sv =====
`default_nettype none

// Unsigned restoring divider, two quotient bits per cycle.
// Caller pre-aligns: rem_init holds the leading dividend bits (must be < divisor),
// num_init holds the remaining 2*steps bits left-aligned. Quotient ends in num_q.
module pidvdt_div import pidvdt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_REM_W-1:0] rem_init,
	input  logic [DIV_NUM_W-1:0] num_init,
	input  logic [DIV_REM_W-1:0] divisor,
	input  logic [DIV_CNT_W-1:0] steps,
	output logic                 busy,
	output logic [DIV_NUM_W-1:0] quotient
);

	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_REM_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [DIV_REM_W-1:0] rem_nx;
	logic [DIV_NUM_W-1:0] num_nx;
	logic [DIV_REM_W:0]   trial;
	logic [DIV_REM_W:0]   diff;

	always_comb begin
		rem_nx = rem_q;
		num_nx = num_q;
		trial  = '0;
		diff   = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_nx, num_nx[DIV_NUM_W-1]};
			diff  = trial - {1'b0, dvs_q};
			if (trial >= {1'b0, dvs_q}) begin
				rem_nx = diff[DIV_REM_W-1:0];
				num_nx = {num_nx[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[DIV_REM_W-1:0];
				num_nx = {num_nx[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num_init;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= num_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

// ===== design/pidvdt_dpath.sv =====
`default_nettype none

module pidvdt_dpath import pidvdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] measured_value,
	input  logic        [31:0] now_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive_value,
	output logic               saturated,
	input  logic               cfg_valid,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	// gains and loop state
	logic [15:0] kp_q, ki_q, kd_q;
	logic [31:0] last_time_q;
	logic [16:0] last_err_q;
	logic [47:0] integral_q;

	// per-step working registers
	logic [31:0] now_q;
	logic [16:0] err_q;
	logic [24:0] dt_q;
	logic        sat_q;
	logic [30:0] p_mag_q;
	logic        p_neg_q;
	logic [31:0] t_mag_q;
	logic        t_neg_q;
	logic [56:0] prod_q;
	logic [61:0] acc_q;

	logic        out_valid_q;
	logic [31:0] drive_q;
	logic        sat_out_q;

	// integral scaling unit: base 2^16 long division by 15625
	logic [63:0] cd_x_q;
	logic [13:0] cd_r_q;
	logic [15:0] cd_d_q;
	logic [1:0]  cd_cnt_q;
	logic        cd_ph_q;
	logic        cd_busy_q;
	logic [29:0] cd_v;
	logic [60:0] cd_prod;
	logic [29:0] cd_back;
	logic [29:0] cd_rem;

	logic [16:0] err_in;
	logic [31:0] dt_diff;
	logic [24:0] dt_in;
	logic [16:0] err_abs;
	logic [15:0] err_mag;
	logic [17:0] derr;
	logic [17:0] derr_abs;
	logic [16:0] derr_mag;
	logic [15:0] g_sel;
	logic [15:0] g_mag;
	logic [31:0] mul_a;
	logic [24:0] mul_b;
	logic [56:0] mul_p;

	logic                 div_start;
	logic                 div_busy;
	logic [DIV_REM_W-1:0] div_rem_init;
	logic [DIV_NUM_W-1:0] div_num_init;
	logic [DIV_REM_W-1:0] div_divisor;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [DIV_NUM_W-1:0] div_quot;

	logic [43:0] q_i;
	logic [49:0] int_sum;
	logic [47:0] int_new;
	logic        int_clip;
	logic [51:0] d_mag;
	logic [61:0] rnd;
	logic [45:0] q_out;
	logic        out_clip;
	logic [31:0] drive_nx;
	logic        out_load;

	// input capture
	assign err_in  = {setpoint[15], setpoint} - {measured_value[15], measured_value};
	assign dt_diff = now_us - last_time_q;
	assign dt_in   = (dt_diff > 32'(DT_CAP_US)) ? DT_CAP_US : dt_diff[24:0];

	// magnitudes feeding the unsigned multiplier
	assign err_abs  = err_q[16] ? (~err_q + 17'd1) : err_q;
	assign err_mag  = err_abs[15:0];
	assign derr     = {err_q[16], err_q} - {last_err_q[16], last_err_q};
	assign derr_abs = derr[17] ? (~derr + 18'd1) : derr;
	assign derr_mag = derr_abs[16:0];

	always_comb begin
		case (cmd.op)
			OP_MUL_KI: g_sel = ki_q;
			OP_MUL_KD: g_sel = kd_q;
			default:   g_sel = kp_q;
		endcase
	end

	assign g_mag = g_sel[15] ? (~g_sel + 16'd1) : g_sel;

	always_comb begin
		case (cmd.op)
			OP_MUL_P, OP_MUL_KI: begin
				mul_a = {16'd0, g_mag};
				mul_b = {9'd0, err_mag};
			end
			OP_MUL_KIDT: begin
				mul_a = t_mag_q;
				mul_b = dt_q;
			end
			OP_MUL_KD: begin
				mul_a = {16'd0, g_mag};
				mul_b = {8'd0, derr_mag};
			end
			OP_MUL_KD6: begin
				mul_a = t_mag_q;
				mul_b = US_PER_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {25'd0, mul_a} * {32'd0, mul_b};

	// integral: (|ki*e|*dt*256)/1e6 == (|ki*e|*dt*4)/15625, four 16-bit digits,
	// each estimated by a reciprocal multiply and then its remainder taken back
	assign cd_v    = {cd_r_q, cd_x_q[63:48]};
	assign cd_prod = {31'd0, cd_v} * {30'd0, CDIV_RECIP};
	assign cd_back = {14'd0, cd_d_q} * {16'd0, CDIV_DEN};
	assign cd_rem  = cd_v - cd_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_busy_q <= 1'b0;
			cd_cnt_q  <= '0;
			cd_ph_q   <= 1'b0;
		end else if (cmd.op == OP_DIV_I) begin
			cd_busy_q <= 1'b1;
			cd_cnt_q  <= '0;
			cd_ph_q   <= 1'b0;
		end else if (cd_busy_q) begin
			cd_ph_q <= !cd_ph_q;
			if (cd_ph_q) begin
				cd_cnt_q <= cd_cnt_q + 2'd1;
				if (cd_cnt_q == 2'd3) begin
					cd_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV_I) begin
			cd_x_q <= {5'd0, prod_q, 2'd0};
			cd_r_q <= '0;
		end else if (cd_busy_q) begin
			if (!cd_ph_q) begin
				cd_d_q <= cd_prod[59:44];
			end else begin
				cd_r_q <= cd_rem[13:0];
				cd_x_q <= {cd_x_q[47:0], cd_d_q};
			end
		end
	end

	// divider: derivative divides |kd*de|*1e6 by dt
	assign div_start    = (cmd.op == OP_DIV_D);
	assign div_rem_init = '0;
	assign div_num_init = {prod_q[51:0], 12'd0};
	assign div_divisor  = dt_q;
	assign div_steps    = DIV_STEPS_D;

	pidvdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.num_init (div_num_init),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// integral update with 48-bit clamp
	assign q_i     = cd_x_q[43:0];
	assign int_sum = t_neg_q ? ({{2{integral_q[47]}}, integral_q} - {6'd0, q_i})
	                         : ({{2{integral_q[47]}}, integral_q} + {6'd0, q_i});

	always_comb begin
		int_clip = 1'b0;
		int_new  = int_sum[47:0];
		if (int_sum[49:47] != 3'b000 && int_sum[49:47] != 3'b111) begin
			int_clip = 1'b1;
			int_new  = int_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
	end

	// no derivative term on zero elapsed time
	assign d_mag = (dt_q == 25'd0) ? '0 : div_quot[51:0];

	// Q.16 to integer, toward zero, then 32-bit clamp
	assign rnd      = acc_q + (acc_q[61] ? 62'd65535 : 62'd0);
	assign q_out    = rnd[61:16];
	assign out_clip = (q_out[45:31] != '0) && (q_out[45:31] != '1);
	assign drive_nx = out_clip ? (q_out[45] ? 32'h8000_0000 : 32'h7FFF_FFFF) : q_out[31:0];

	assign out_load = (cmd.op == OP_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			last_time_q <= '0;
			last_err_q  <= '0;
			integral_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KP:  kp_q <= cfg_data;
					REG_KI:  ki_q <= cfg_data;
					REG_KD:  kd_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_INT_UPD) begin
				integral_q <= int_new;
			end
			if (out_load) begin
				last_time_q <= now_q;
				last_err_q  <= err_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				err_q <= err_in;
				dt_q  <= dt_in;
				now_q <= now_us;
				sat_q <= 1'b0;
			end
			OP_MUL_P: begin
				p_mag_q <= mul_p[30:0];
				p_neg_q <= kp_q[15] ^ err_q[16];
			end
			OP_MUL_KI: begin
				t_mag_q <= mul_p[31:0];
				t_neg_q <= ki_q[15] ^ err_q[16];
			end
			OP_MUL_KD: begin
				t_mag_q <= mul_p[31:0];
				t_neg_q <= kd_q[15] ^ derr[17];
			end
			OP_MUL_KIDT, OP_MUL_KD6: begin
				prod_q <= mul_p;
			end
			OP_INT_UPD: begin
				sat_q <= sat_q | int_clip;
			end
			OP_SUM_P: begin
				acc_q <= p_neg_q ? ({{14{integral_q[47]}}, integral_q} - {23'd0, p_mag_q, 8'd0})
				                 : ({{14{integral_q[47]}}, integral_q} + {23'd0, p_mag_q, 8'd0});
			end
			OP_SUM_D: begin
				acc_q <= t_neg_q ? (acc_q - {2'd0, d_mag, 8'd0})
				                 : (acc_q + {2'd0, d_mag, 8'd0});
			end
			OP_OUT: begin
				drive_q   <= drive_nx;
				sat_out_q <= sat_q | out_clip;
			end
			default: ;
		endcase
	end

	assign sts.div_busy = div_busy || cd_busy_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign saturated   = sat_out_q;

endmodule

`default_nettype wire

// ===== design/pidvdt_ctrl.sv =====
`default_nettype none

`include "pid_controller_variable_dt_macros.svh"

module pidvdt_ctrl import pidvdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_nx = S_MUL_P;
			S_MUL_P:    state_nx = S_MUL_KI;
			S_MUL_KI:   state_nx = S_MUL_KIDT;
			S_MUL_KIDT: state_nx = S_DIV_I;
			S_DIV_I:    state_nx = S_WAIT_I;
			S_WAIT_I:   if (!sts.div_busy) state_nx = S_INT_UPD;
			S_INT_UPD:  state_nx = S_MUL_KD;
			S_MUL_KD:   state_nx = S_MUL_KD6;
			S_MUL_KD6:  state_nx = S_DIV_D;
			S_DIV_D:    state_nx = S_WAIT_D;
			S_WAIT_D:   if (!sts.div_busy) state_nx = S_SUM_P;
			S_SUM_P:    state_nx = S_SUM_D;
			S_SUM_D:    state_nx = S_OUT;
			S_OUT:      if (sts.out_free) state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
			S_MUL_P:    cmd.op = OP_MUL_P;
			S_MUL_KI:   cmd.op = OP_MUL_KI;
			S_MUL_KIDT: cmd.op = OP_MUL_KIDT;
			S_DIV_I:    cmd.op = OP_DIV_I;
			S_INT_UPD:  cmd.op = OP_INT_UPD;
			S_MUL_KD:   cmd.op = OP_MUL_KD;
			S_MUL_KD6:  cmd.op = OP_MUL_KD6;
			S_DIV_D:    cmd.op = OP_DIV_D;
			S_SUM_P:    cmd.op = OP_SUM_P;
			S_SUM_D:    cmd.op = OP_SUM_D;
			S_OUT:      if (sts.out_free) cmd.op = OP_OUT;
			default:    cmd.op = OP_NONE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	`PIDVDT_ASSERT_IMPL(a_div_idle_on_accept, state_q == S_IDLE, !sts.div_busy, "divider busy in idle")
	`PIDVDT_ASSERT_IMPL(a_out_load_free, cmd.op == OP_OUT, sts.out_free, "result loaded over a held beat")
	`PIDVDT_ASSERT_IMPL(a_div_start_src, $rose(sts.div_busy), $past(cmd.op == OP_DIV_I || cmd.op == OP_DIV_D), "divider started without command")

endmodule

`default_nettype wire

// ===== design/pid_controller_variable_dt.sv =====
// Channel  | Handshake          | Payload                              | Dir
// ---------+--------------------+--------------------------------------+-----
// in       | in_valid/in_stall  | setpoint, measured_value, now_us     | in
// out      | out_valid/out_stall| drive_value, saturated               | out
// cfg      | cfg_valid/cfg_ready| cfg_index (0 kp, 1 ki, 2 kd), cfg_data| in
//
// A step runs from input beat to result through five multiplier passes, the integral
// /1e6 as four reciprocal digits, the derivative /dt on the radix-4 divider (26 steps)
// and the issue/add states; a new beat waits until the step is back in idle.
// in_stall is low only in idle; a beat is accepted while the previous result still
// waits on out_stall, and the block then holds in its last state until it frees.
// Reset (arst_n, async low) clears gains, loop state and output valid; cfg_ready is high.
`default_nettype none

module pid_controller_variable_dt import pidvdt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// control step input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] measured_value,
	input  logic        [31:0] now_us,
	// result
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive_value,
	output logic               saturated,
	// gain writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// gains are plain registers, so every write is taken at once
	assign cfg_ready = 1'b1;

	// sequencer: walks P, integral and derivative terms through the shared units
	pidvdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: gains, loop state, multiplier, divider, output register
	pidvdt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.setpoint       (setpoint),
		.measured_value (measured_value),
		.now_us         (now_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_value    (drive_value),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

endmodule

`default_nettype wire
